// ===== hdl/jjdp_pkg.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser package
// Shared types, byte constants, result codes and the JFIF signature table.
// ----------------------------------------------------------------------------
package jjdp_pkg;

  // Marker and segment bytes.
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_APP0 = 8'hE0;

  // Smallest APP0 length that can hold the JFIF header.
  localparam logic [15:0] JFIF_MIN_LEN = 16'd16;

  // Default resolution after reset.
  localparam logic [15:0] DEFAULT_DPI_RST = 16'd96;

  // Result status codes.
  localparam logic [1:0] ST_JFIF    = 2'd0;
  localparam logic [1:0] ST_NOTJPEG = 2'd1;
  localparam logic [1:0] ST_STOP    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } jjdp_item_t;

  // One result word.
  typedef struct packed {
    logic [15:0] dpi_h;
    logic [15:0] dpi_v;
    logic [1:0]  status;
  } jjdp_result_t;

  // The four signature bytes "JFIF" at the start of the APP0 payload.
  function automatic logic [7:0] jfif_tag_byte(input logic [1:0] idx);
    logic [7:0] tag;
    case (idx)
      2'd0:    tag = 8'h4A;
      2'd1:    tag = 8'h46;
      2'd2:    tag = 8'h49;
      default: tag = 8'h46;
    endcase
    return tag;
  endfunction

endpackage

// ===== hdl/jjdp_in_stage.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser input register
// Holds one accepted word until the parse stage consumes it.
// ----------------------------------------------------------------------------
module jjdp_in_stage
  import jjdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  jjdp_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output jjdp_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  jjdp_item_t item_r;
  logic       load;

  // The register takes a new word when empty or when its word moves on.
  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/jjdp_parse.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser segment walker
// Per-byte state machine: start marker check, segment walk, APP0/JFIF decode.
// ----------------------------------------------------------------------------
module jjdp_parse
  import jjdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  jjdp_item_t   item,
  input  logic [15:0]  default_dpi,
  output logic         emit,
  output jjdp_result_t result
);

  localparam logic [2:0] PH_SIG0    = 3'd0;
  localparam logic [2:0] PH_SIG1    = 3'd1;
  localparam logic [2:0] PH_SEG_FF  = 3'd2;
  localparam logic [2:0] PH_MARKER  = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [2:0]  phase_r,  phase_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic        sig_r,    sig_nxt;
  logic [7:0]  units_r,  units_nxt;
  logic [15:0] xden_r,   xden_nxt;
  logic [15:0] yden_r,   yden_nxt;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [16:0] cnt_end;
  logic [1:0]  status;
  logic        use_jfif;
  logic [15:0] jfif_h;
  logic [15:0] jfif_v;

  assign b        = item.data_byte;
  assign len_full = {len_r[15:8], b};
  assign cnt_end  = {1'b0, cnt_r} + 17'd3;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sig_nxt    = sig_r;
    units_nxt  = units_r;
    xden_nxt   = xden_r;
    yden_nxt   = yden_r;
    emit       = 1'b0;
    status     = ST_BAD;
    use_jfif   = 1'b0;
    jfif_h     = default_dpi;
    jfif_v     = default_dpi;

    case (phase_r)
      PH_SIG0: begin
        if (b == BYTE_FF) begin
          phase_nxt = PH_SIG1;
        end else begin
          emit   = 1'b1;
          status = ST_NOTJPEG;
        end
      end
      PH_SIG1: begin
        if (b == BYTE_SOI) begin
          phase_nxt = PH_SEG_FF;
        end else begin
          emit   = 1'b1;
          status = ST_NOTJPEG;
        end
      end
      PH_SEG_FF: begin
        if (b == BYTE_FF) begin
          phase_nxt = PH_MARKER;
        end else begin
          emit   = 1'b1;
          status = ST_BAD;
        end
      end
      PH_MARKER: begin
        if (b inside {BYTE_SOI, BYTE_EOI, BYTE_SOS}) begin
          emit   = 1'b1;
          status = ST_STOP;
        end else begin
          marker_nxt = b;
          phase_nxt  = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_nxt   = {b, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = len_full;
        if (len_full < 16'd2) begin
          emit   = 1'b1;
          status = ST_BAD;
        end else if (len_full == 16'd2) begin
          phase_nxt = PH_SEG_FF;
        end else begin
          cnt_nxt   = '0;
          sig_nxt   = (marker_r == BYTE_APP0) && (len_full >= JFIF_MIN_LEN);
          units_nxt = '0;
          xden_nxt  = '0;
          yden_nxt  = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // Pick the JFIF header fields out of the payload by position.
        if (cnt_r < 16'd4) begin
          if (b != jfif_tag_byte(cnt_r[1:0])) begin
            sig_nxt = 1'b0;
          end
        end else begin
          case (cnt_r)
            16'd7:   units_nxt = b;
            16'd8:   xden_nxt  = {b, 8'h00};
            16'd9:   xden_nxt  = {xden_r[15:8], b};
            16'd10:  yden_nxt  = {b, 8'h00};
            16'd11:  yden_nxt  = {yden_r[15:8], b};
            default: ;
          endcase
        end
        cnt_nxt = cnt_r + 16'd1;
        // Last payload byte: commit JFIF or move to the next segment.
        if (cnt_end >= {1'b0, len_r}) begin
          if (sig_nxt) begin
            emit     = 1'b1;
            status   = ST_JFIF;
            use_jfif = 1'b1;
            // Density is used only for units of dots per inch and a nonzero value.
            if (units_nxt == 8'd1 && xden_nxt != 16'd0) begin
              jfif_h = xden_nxt;
            end
            if (units_nxt == 8'd1 && yden_nxt != 16'd0) begin
              jfif_v = yden_nxt;
            end
          end else begin
            phase_nxt = PH_SEG_FF;
          end
        end
      end
      default: ;
    endcase

    if (emit) begin
      phase_nxt = PH_DONE;
    end

    // End of file: report defaults if nothing was sent, then rearm.
    if (item.last_byte) begin
      if (phase_nxt != PH_DONE) begin
        emit   = 1'b1;
        status = (phase_nxt == PH_SIG0 || phase_nxt == PH_SIG1) ? ST_NOTJPEG : ST_BAD;
      end
      phase_nxt  = PH_SIG0;
      marker_nxt = '0;
      len_nxt    = '0;
      cnt_nxt    = '0;
      sig_nxt    = 1'b0;
      units_nxt  = '0;
      xden_nxt   = '0;
      yden_nxt   = '0;
    end
  end

  always_comb begin
    result.status = status;
    result.dpi_h  = use_jfif ? jfif_h : default_dpi;
    result.dpi_v  = use_jfif ? jfif_v : default_dpi;
  end

  // Parser state advances once per consumed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG0;
      marker_r <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      sig_r    <= 1'b0;
      units_r  <= '0;
      xden_r   <= '0;
      yden_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      marker_r <= marker_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      sig_r    <= sig_nxt;
      units_r  <= units_nxt;
      xden_r   <= xden_nxt;
      yden_r   <= yden_nxt;
    end
  end

endmodule

// ===== hdl/jjdp_out_stage.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module jjdp_out_stage
  import jjdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  jjdp_result_t result,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output jjdp_result_t out_result
);

  logic         valid_r;
  logic         valid_nxt;
  jjdp_result_t result_r;

  // Room for a new word when empty or when the held word leaves now.
  assign free = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== hdl/jpeg_jfif_density_parser_core.sv =====
// ----------------------------------------------------------------------------
// JPEG JFIF density parser
// Reads a file one byte per word and reports its resolution once per file.
// ----------------------------------------------------------------------------
// The block takes one byte every cycle and gives at most one result word per
// file: the JFIF X/Y density when an APP0 JFIF segment with units of dots per
// inch is found, otherwise cfg_default_dpi on both axes with a status code.
// A byte passes through an input register and the per-byte parse logic, and
// its result is loaded into the output register once that register has room.
// Input stalls only when a byte that yields a result meets a full, stalled
// output register.
// cfg_default_dpi may be written only while no file is in flight.
module jpeg_jfif_density_parser_core
  import jjdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_default_dpi,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_dpi_h,
  output logic [15:0] out_dpi_v,
  output logic [1:0]  out_status
);

  logic [15:0]  default_dpi_r;
  jjdp_item_t   in_item;
  jjdp_item_t   item;
  logic         item_valid;
  logic         emit;
  logic         out_free;
  logic         advance;
  jjdp_result_t result;
  jjdp_result_t out_result;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_dpi_r <= DEFAULT_DPI_RST;
    end else if (cfg_wr_en) begin
      default_dpi_r <= cfg_default_dpi;
    end
  end

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // A held byte moves on unless its result has nowhere to go.
  assign advance = item_valid && (!emit || out_free);

  jjdp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  jjdp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (item),
    .default_dpi (default_dpi_r),
    .emit        (emit),
    .result      (result)
  );

  jjdp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && emit),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_dpi_h  = out_result.dpi_h;
  assign out_dpi_v  = out_result.dpi_v;
  assign out_status = out_result.status;

endmodule

// ===== hdl/jjdp_checker.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser port checker
// Watches the top level's ports and flags behavior the design must not show.
// ----------------------------------------------------------------------------
module jjdp_checker
  import jjdp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_dpi_h,
  input logic [15:0] out_dpi_v,
  input logic [1:0]  out_status
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dpi_h) &&
      $stable(out_dpi_v) && $stable(out_status))
    else $error("result word changed while stalled");

  // A byte word waiting at the input keeps its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) &&
      $stable(in_last_byte))
    else $error("byte word changed while stalled");

  // The block is ready for a byte right after reset.
  a_ready_after_rst: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

  // With the output register empty, input is never stalled.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A result without JFIF density carries the default on both axes.
  a_default_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_JFIF |-> out_dpi_h == out_dpi_v)
    else $error("default result with unequal axes");

endmodule

bind jpeg_jfif_density_parser_core jjdp_checker u_jjdp_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// JFIF density parser testbench
// Streams whole files through the byte port and checks every resolution word.
// ----------------------------------------------------------------------------
// Files are built as byte lists and loaded into a word queue. A clocked
// driver offers them with random gaps. A clocked monitor takes results with
// random stalls, including long hold-offs that back the parser up. Each
// accepted byte runs through a local copy of the parser walk, and the
// words it yields are queued and compared field by field in arrival order.
// The default resolution is rewritten between file groups, only while idle.
module tb_top
  import jjdp_pkg::*;
;

  localparam int          PHASES        = 6;
  localparam int          PHASE_BYTES   = 130;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 2000;
  localparam logic [31:0] JFIF_SIG      = 32'h4A464946;

  typedef enum logic [2:0] {
    WALK_SIG0, WALK_SIG1, WALK_SEG_FF, WALK_MARKER,
    WALK_LEN_HI, WALK_LEN_LO, WALK_PAYLOAD, WALK_DONE
  } walk_phase_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_wr_en       = 1'b0;
  logic [15:0] cfg_default_dpi = 16'h0000;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_last_byte    = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [15:0] out_dpi_h;
  logic [15:0] out_dpi_v;
  logic [1:0]  out_status;

  // Words waiting to be sent, and resolution words still owed by the block.
  jjdp_item_t   byte_queue[$];
  jjdp_result_t expected_dpi[$];
  logic [7:0]   file_bytes[$];
  int           bytes_queued  = 0;
  int           mismatches    = 0;
  int           results_seen  = 0;
  int           long_holds    = 0;
  int           send_gap      = 0;
  int           stall_left    = 0;
  int           quiet_cycles  = 0;
  bit           steady_flow   = 1'b0;

  // Local copy of the parser walk and the resolution register.
  walk_phase_t  walk;
  logic [7:0]   seg_marker;
  logic [15:0]  seg_len;
  logic [15:0]  pay_cnt;
  logic         tag_ok;
  logic [7:0]   units;
  logic [15:0]  x_dens;
  logic [15:0]  y_dens;
  logic         reported;
  logic [15:0]  model_dpi;

  jpeg_jfif_density_parser_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_default_dpi (cfg_default_dpi),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dpi_h       (out_dpi_h),
    .out_dpi_v       (out_dpi_v),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clear the walk for a new file.
  function automatic void rearm_walk();
    walk       = WALK_SIG0;
    seg_marker = 8'h00;
    seg_len    = 16'h0000;
    pay_cnt    = 16'h0000;
    tag_ok     = 1'b0;
    units      = 8'h00;
    x_dens     = 16'h0000;
    y_dens     = 16'h0000;
    reported   = 1'b0;
  endfunction

  // Queue the one resolution word of the current file.
  function automatic void post_result(input logic [15:0] h, input logic [15:0] v,
                                      input logic [1:0] st);
    jjdp_result_t r;
    r.dpi_h  = h;
    r.dpi_v  = v;
    r.status = st;
    expected_dpi.insert(expected_dpi.size(), r);
    reported = 1'b1;
    walk     = WALK_DONE;
  endfunction

  // Append one byte to the file being built.
  function automatic void add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  // Advance the walk by one accepted byte.
  function automatic void track_byte(input logic [7:0] b, input logic is_last);
    logic [15:0] h;
    logic [15:0] v;
    case (walk)
      WALK_SIG0: begin
        if (b == BYTE_FF) walk = WALK_SIG1;
        else post_result(model_dpi, model_dpi, ST_NOTJPEG);
      end
      WALK_SIG1: begin
        if (b == BYTE_SOI) walk = WALK_SEG_FF;
        else post_result(model_dpi, model_dpi, ST_NOTJPEG);
      end
      WALK_SEG_FF: begin
        if (b == BYTE_FF) walk = WALK_MARKER;
        else post_result(model_dpi, model_dpi, ST_BAD);
      end
      WALK_MARKER: begin
        if (b == BYTE_SOI || b == BYTE_EOI || b == BYTE_SOS) begin
          post_result(model_dpi, model_dpi, ST_STOP);
        end else begin
          seg_marker = b;
          walk       = WALK_LEN_HI;
        end
      end
      WALK_LEN_HI: begin
        seg_len = {b, 8'h00};
        walk    = WALK_LEN_LO;
      end
      WALK_LEN_LO: begin
        seg_len[7:0] = b;
        if (seg_len < 16'd2) begin
          post_result(model_dpi, model_dpi, ST_BAD);
        end else if (seg_len == 16'd2) begin
          walk = WALK_SEG_FF;
        end else begin
          pay_cnt = 16'h0000;
          tag_ok  = (seg_marker == BYTE_APP0) && (seg_len >= JFIF_MIN_LEN);
          units   = 8'h00;
          x_dens  = 16'h0000;
          y_dens  = 16'h0000;
          walk    = WALK_PAYLOAD;
        end
      end
      WALK_PAYLOAD: begin
        // The signature comes first, then units and the two densities.
        if (pay_cnt < 16'd4) begin
          if (b != JFIF_SIG[8 * (3 - pay_cnt[1:0]) +: 8]) tag_ok = 1'b0;
        end else begin
          case (pay_cnt)
            16'd7:   units        = b;
            16'd8:   x_dens[15:8] = b;
            16'd9:   x_dens[7:0]  = b;
            16'd10:  y_dens[15:8] = b;
            16'd11:  y_dens[7:0]  = b;
            default: ;
          endcase
        end
        pay_cnt = pay_cnt + 16'd1;
        if ({1'b0, pay_cnt} + 17'd2 >= {1'b0, seg_len}) begin
          if (tag_ok) begin
            h = (units == 8'd1 && x_dens != 16'h0000) ? x_dens : model_dpi;
            v = (units == 8'd1 && y_dens != 16'h0000) ? y_dens : model_dpi;
            post_result(h, v, ST_JFIF);
          end else begin
            walk = WALK_SEG_FF;
          end
        end
      end
      default: ;
    endcase

    // The last byte of a file forces a word if none came yet, then rearms.
    if (is_last) begin
      if (!reported) begin
        post_result(model_dpi, model_dpi,
                    (walk == WALK_SIG0 || walk == WALK_SIG1) ? ST_NOTJPEG : ST_BAD);
      end
      rearm_walk();
    end
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) g = 0;
    else if (r < 88) g = $urandom_range(1, 3);
    else if (r < 97) g = $urandom_range(4, 12);
    else g = $urandom_range(20, 60);
    return g;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Any marker byte that does not stop the walk.
  function automatic logic [7:0] plain_marker();
    logic [7:0] mk;
    mk = rand_byte();
    if (mk == BYTE_SOI || mk == BYTE_EOI || mk == BYTE_SOS) mk = BYTE_APP0 + 8'd1;
    return mk;
  endfunction

  function automatic logic [15:0] rand_density();
    logic [15:0] d;
    case ($urandom_range(0, 7))
      0:       d = 16'h0000;
      1:       d = 16'hFFFF;
      default: d = 16'($urandom);
    endcase
    return d;
  endfunction

  // Move the built file into the word queue, flagging its final byte.
  task automatic commit_file();
    jjdp_item_t w;
    for (int k = 0; k < file_bytes.size(); k++) begin
      w.data_byte = file_bytes[k];
      w.last_byte = (k == file_bytes.size() - 1);
      byte_queue.insert(byte_queue.size(), w);
    end
    bytes_queued += file_bytes.size();
    file_bytes.delete();
  endtask

  // Append an APP0 segment laid out as a JFIF header plus padding.
  task automatic put_app0(input logic [15:0] len, input logic [7:0] unit_code,
                          input logic [15:0] xd, input logic [15:0] yd,
                          input logic spoil_tag);
    int idx;
    add_byte(BYTE_FF);
    add_byte(BYTE_APP0);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int k = 0; k < 4; k++) add_byte(JFIF_SIG[8 * (3 - k) +: 8]);
    if (spoil_tag) begin
      idx = file_bytes.size() - 1 - $urandom_range(0, 3);
      file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
    end
    add_byte(8'h00);
    add_byte(rand_byte());
    add_byte(rand_byte());
    add_byte(unit_code);
    add_byte(xd[15:8]);
    add_byte(xd[7:0]);
    add_byte(yd[15:8]);
    add_byte(yd[7:0]);
    for (int k = 14; k < len; k++) add_byte(rand_byte());
  endtask

  // Append a short segment that never yields a result; some are APP0
  // segments too short to qualify, possibly carrying the signature.
  task automatic put_other_segment();
    logic [7:0]  mk;
    logic [15:0] len;
    logic        copy_tag;
    mk       = ($urandom_range(0, 3) == 0) ? BYTE_APP0 : plain_marker();
    len      = (mk == BYTE_APP0) ? 16'($urandom_range(2, 15)) : 16'($urandom_range(2, 9));
    copy_tag = $urandom_range(0, 1);
    add_byte(BYTE_FF);
    add_byte(mk);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int k = 0; k < len - 2; k++) begin
      if (mk == BYTE_APP0 && copy_tag && k < 4) add_byte(JFIF_SIG[8 * (3 - k) +: 8]);
      else add_byte(rand_byte());
    end
  endtask

  // Build one random file: mostly well-formed walks, some noise and damage.
  task automatic add_random_file();
    int         kind;
    int         cut;
    logic [7:0] b;
    logic [7:0] unit_code;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 5)) add_byte(rand_byte());
    end else begin
      add_byte(BYTE_FF);
      add_byte(BYTE_SOI);
      if (kind < 12) file_bytes[$urandom_range(0, 1)] = rand_byte();
      repeat ($urandom_range(0, 2)) put_other_segment();
      if (kind < 70) begin
        case ($urandom_range(0, 9))
          0:       unit_code = 8'd0;
          1:       unit_code = 8'd2;
          2:       unit_code = rand_byte();
          default: unit_code = 8'd1;
        endcase
        put_app0(($urandom_range(0, 3) == 0) ? 16'($urandom_range(17, 22)) : JFIF_MIN_LEN,
                 unit_code, rand_density(), rand_density(), $urandom_range(0, 9) == 0);
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            add_byte(BYTE_FF);
            case ($urandom_range(0, 2))
              0:       add_byte(BYTE_SOI);
              1:       add_byte(BYTE_EOI);
              default: add_byte(BYTE_SOS);
            endcase
          end
          1: begin
            b = rand_byte();
            if (b == BYTE_FF) b = 8'h00;
            add_byte(b);
          end
          2: begin
            add_byte(BYTE_FF);
            add_byte(plain_marker());
            add_byte(8'h00);
            add_byte(8'($urandom_range(0, 1)));
          end
          3: begin
            // A huge length that the file never fills.
            add_byte(BYTE_FF);
            add_byte(plain_marker());
            add_byte(8'hFF);
            add_byte(rand_byte());
            repeat ($urandom_range(0, 4)) add_byte(rand_byte());
          end
          default: ;
        endcase
      end
      repeat ($urandom_range(0, 3)) add_byte(rand_byte());
    end
    if ($urandom_range(0, 99) < 12) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    commit_file();
  endtask

  // Wait until every word is sent and every result is back, then let the
  // pipeline run dry.
  task automatic settle();
    while (byte_queue.size() != 0 || in_valid || expected_dpi.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver: track accepted words, then offer the next one after a gap.
  always @(posedge clk) begin : byte_driver
    jjdp_item_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_byte(in_data_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          w = byte_queue.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= w.data_byte;
          in_last_byte <= w.last_byte;
          send_gap = idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted word, then pick the next ready.
  always @(posedge clk) begin : result_monitor
    jjdp_result_t want;
    int           g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_dpi.size() == 0) begin
          $error("unexpected result word: dpi_h %0d dpi_v %0d status %0d",
                 out_dpi_h, out_dpi_v, out_status);
          mismatches++;
        end else begin
          want = expected_dpi.pop_front();
          if (out_dpi_h !== want.dpi_h) begin
            $error("dpi_h: expected %0d, got %0d", want.dpi_h, out_dpi_h);
            mismatches++;
          end
          if (out_dpi_v !== want.dpi_v) begin
            $error("dpi_v: expected %0d, got %0d", want.dpi_v, out_dpi_v);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
      end

      // Two long hold-offs let the block fill up and stall its input.
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_holds < 2 && results_seen >= 12 + 60 * long_holds) begin
        long_holds++;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        g = idle_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = g - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin : stall_watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("jpeg_jfif_density_parser_core: mismatch");
        $finish;
      end
    end
  end

  // Directed files at the reset resolution, then random file groups, each
  // with its own default resolution.
  initial begin : stimulus
    logic [15:0] dpi;
    int          target;
    rearm_walk();
    model_dpi = DEFAULT_DPI_RST;

    // First byte is not a start byte.
    file_bytes = '{8'h00};
    commit_file();
    // Wrong second byte, then bytes ignored until the end of the file.
    file_bytes = '{BYTE_FF, 8'h00, 8'h55};
    commit_file();
    // File ends right after the start marker.
    file_bytes = '{BYTE_FF, BYTE_SOI};
    commit_file();
    // Empty segment, then a byte other than FF where a segment must begin.
    file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, 8'hC0, 8'h00, 8'h02, 8'h00};
    commit_file();
    // End-of-image marker stops the walk.
    file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_EOI};
    commit_file();
    // Segment length below two.
    file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, 8'hC4, 8'h00, 8'h01};
    commit_file();
    // JFIF header with full-scale X density and a zero Y density.
    file_bytes = '{BYTE_FF, BYTE_SOI};
    put_app0(JFIF_MIN_LEN, 8'd1, 16'hFFFF, 16'h0000, 1'b0);
    commit_file();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       dpi = 16'h0000;
        1:       dpi = 16'hFFFF;
        3:       dpi = 16'h0001;
        default: dpi = 16'($urandom);
      endcase
      @(posedge clk);
      cfg_wr_en       <= 1'b1;
      cfg_default_dpi <= dpi;
      model_dpi = dpi;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      steady_flow = (p == 4);
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) add_random_file();
      settle();
    end

    if (mismatches == 0 && expected_dpi.size() == 0) begin
      $display("jpeg_jfif_density_parser_core: match");
    end else begin
      $display("jpeg_jfif_density_parser_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== jpeg_jfif_density_parser_core.f =====
hdl/jjdp_pkg.sv
hdl/jjdp_in_stage.sv
hdl/jjdp_parse.sv
hdl/jjdp_out_stage.sv
hdl/jpeg_jfif_density_parser_core.sv
hdl/jjdp_checker.sv
tb/tb_top.sv
